/* src/iat_pkg.sv */
// shared types, codes and defaults for the interval allocation table
package iat_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 16;
   localparam int unsigned DATA_W = 32;

   typedef enum logic [2:0] {
      MODE_ALLOC   = 3'd0,
      MODE_RELEASE = 3'd1,
      MODE_CHECK   = 3'd2,
      MODE_LIST    = 3'd3,
      MODE_MERGE   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMP_VALID   = 2'd0,
      CMP_OVERLAP = 2'd1,
      CMP_AFTER   = 2'd2,
      CMP_MERGE   = 2'd3
   } cmp_op_type;

   typedef struct packed {
      logic        hit;
      logic        grow;
   } cmp_res_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] rng_start;
      logic signed [DATA_W-1:0] rng_end;
   } entry_type;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [DATA_W-1:0] req_start;
      logic signed [DATA_W-1:0] req_end;
   } req_payload_type;

   typedef struct packed {
      status_type               status;
      logic                     is_free;
      logic signed [DATA_W-1:0] out_start;
      logic signed [DATA_W-1:0] out_end;
      logic                     last;
   } rsp_payload_type;

endpackage

/* src/iat_if.sv */
// request and response channel interfaces of the interval allocation table
interface iat_req_if;
   import iat_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface iat_rsp_if;
   import iat_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* src/iat_ram.sv */
// generic single write port, single read port ram with registered read
module iat_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/iat_cmp_unit.sv */
// shared signed compare unit: validity, overlap, sort order and merge tests
module iat_cmp_unit (
   input  iat_pkg::cmp_op_type  op,
   input  iat_pkg::entry_type   key,
   input  iat_pkg::entry_type   ent,
   input  iat_pkg::entry_type   acc,
   output iat_pkg::cmp_res_type res
);
   import iat_pkg::*;

   logic signed [DATA_W-1:0] x0, y0, x1, y1;
   logic                     lt0, eq0, lt1;

   // operand steering onto the two comparators
   always_comb begin
      x0 = key.rng_start;
      y0 = key.rng_end;
      x1 = ent.rng_start;
      y1 = key.rng_end;
      case (op)
         CMP_VALID: begin
            x0 = key.rng_start;
            y0 = key.rng_end;
         end
         CMP_OVERLAP: begin
            x0 = key.rng_start;
            y0 = ent.rng_end;
            x1 = ent.rng_start;
            y1 = key.rng_end;
         end
         CMP_AFTER: begin
            x0 = key.rng_start;
            y0 = ent.rng_start;
            x1 = key.rng_end;
            y1 = ent.rng_end;
         end
         CMP_MERGE: begin
            x0 = acc.rng_end;
            y0 = ent.rng_start;
            x1 = acc.rng_end;
            y1 = ent.rng_end;
         end
         default: begin
            x0 = key.rng_start;
            y0 = key.rng_end;
         end
      endcase
   end

   assign lt0 = x0 < y0;
   assign eq0 = x0 == y0;
   assign lt1 = x1 < y1;

   always_comb begin
      res = '0;
      case (op)
         CMP_VALID:   res.hit = lt0;
         CMP_OVERLAP: res.hit = lt0 && lt1;
         CMP_AFTER:   res.hit = lt0 || (eq0 && lt1);
         CMP_MERGE: begin
            res.hit  = !lt0;
            res.grow = lt1;
         end
         default:     res = '0;
      endcase
   end

endmodule

/* src/interval_allocation_table.sv */
// top level of the interval allocation table: sequencer, table memory and response register
//
// keeps up to TABLE_ENTRIES half-open ranges [start, end) in start order in a
// single table memory, and serves one request at a time. a small sequencer
// walks the table one entry at a time (read, then test in the shared compare
// unit), so the cost of a request follows the number of stored ranges n.
// allocate and release first run the overlap removal pass, and allocate then
// moves each stored range above the new one up a slot to make room for it and
// writes it. check free runs the overlap pass without writing. the list modes
// give one response per entry or merged run. an invalid range, an unused mode
// or a list of an empty table gives its one response. req_ch.ready is high
// only while no request is in progress; the response register lets the next
// request in while the last response still waits to be taken. a stalled
// response channel stalls the walk at the entry that wants to emit.
module interval_allocation_table #(
   parameter int unsigned TABLE_ENTRIES = iat_pkg::TABLE_ENTRIES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   iat_req_if.sink   req_ch,
   iat_rsp_if.source rsp_ch
);
   import iat_pkg::*;

   localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

   typedef logic [CW-1:0] cnt_type;
   localparam cnt_type FULL_COUNT = CW'(TABLE_ENTRIES);
   localparam cnt_type ONE        = CW'(1);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DECODE   = 9'b000000010,
      S_SCAN_RD  = 9'b000000100,
      S_SCAN_USE = 9'b000001000,
      S_INS_RD   = 9'b000010000,
      S_INS_USE  = 9'b000100000,
      S_LIST_RD  = 9'b001000000,
      S_LIST_USE = 9'b010000000,
      S_FIN      = 9'b100000000
   } state_type;

   // sequencer state
   state_type  state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   entry_type  key_ff, key_in;
   cnt_type    idx_ff, idx_in;
   cnt_type    wr_ptr_ff, wr_ptr_in;
   cnt_type    count_ff, count_in;
   entry_type  acc_ff, acc_in;
   logic       hit_ff, hit_in;
   status_type res_status_ff, res_status_in;
   logic       res_free_ff, res_free_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   rsp_payload_type rsp_next;
   logic            rsp_load;
   logic            out_free;

   // table memory and compare unit hookup
   logic                    ram_wr_en;
   logic [IW-1:0]           ram_wr_addr;
   entry_type               ram_wr_data;
   logic                    ram_rd_en;
   logic [IW-1:0]           ram_rd_addr;
   logic [$bits(entry_type)-1:0] ram_rd_bits;
   entry_type               ram_rd_data;

   cmp_op_type  cmp_op;
   cmp_res_type cmp_res;

   logic    req_fire;
   cnt_type idx_inc;
   cnt_type pos_dec;
   logic    idx_last;
   logic    need_emit;

   iat_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = entry_type'(ram_rd_bits);

   iat_cmp_unit u_cmp (
      .op  (cmp_op),
      .key (key_ff),
      .ent (ram_rd_data),
      .acc (acc_ff),
      .res (cmp_res)
   );

   // handshakes
   assign req_ch.ready   = (state_ff == S_IDLE);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // walk index arithmetic
   assign idx_inc  = idx_ff + ONE;
   assign pos_dec  = idx_ff - ONE;
   assign idx_last = (idx_inc == count_ff);
   // a merged run closes when the next entry does not touch it
   assign need_emit = (idx_ff != '0) && !cmp_res.hit;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_free_in   = res_free_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff[IW-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff[IW-1:0];
      cmp_op        = CMP_OVERLAP;
      rsp_load      = 1'b0;
      rsp_next      = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in          = req_ch.payload.mode;
               key_in.rng_start = req_ch.payload.req_start;
               key_in.rng_end   = req_ch.payload.req_end;
               state_in         = S_DECODE;
            end
         end

         // validate the range and set up the walk
         S_DECODE: begin
            cmp_op        = CMP_VALID;
            idx_in        = '0;
            wr_ptr_in     = '0;
            hit_in        = 1'b0;
            acc_in        = '0;
            res_status_in = ST_OK;
            res_free_in   = 1'b0;
            case (mode_ff)
               MODE_ALLOC, MODE_RELEASE, MODE_CHECK: begin
                  if (cmp_res.hit) begin
                     state_in = S_SCAN_RD;
                  end else begin
                     res_status_in = ST_INVALID;
                     state_in      = S_FIN;
                  end
               end
               MODE_LIST, MODE_MERGE: begin
                  if (count_ff == '0) begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_FIN;
                  end else begin
                     state_in = S_LIST_RD;
                  end
               end
               default: begin
                  res_status_in = ST_INVALID;
                  state_in      = S_FIN;
               end
            endcase
         end

         // overlap pass: kept entries are compacted down to wr_ptr
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               if (mode_ff == MODE_CHECK) begin
                  res_free_in = !hit_ff;
                  state_in    = S_FIN;
               end else begin
                  count_in = wr_ptr_ff;
                  idx_in   = wr_ptr_ff;
                  if (mode_ff == MODE_ALLOC) begin
                     if (wr_ptr_ff == FULL_COUNT) begin
                        res_status_in = ST_FULL;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end else begin
                     state_in = S_FIN;
                  end
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_SCAN_USE;
            end
         end

         S_SCAN_USE: begin
            cmp_op = CMP_OVERLAP;
            if (cmp_res.hit) begin
               hit_in = 1'b1;
            end else if (mode_ff != MODE_CHECK) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_ptr_ff[IW-1:0];
               ram_wr_data = ram_rd_data;
               wr_ptr_in   = wr_ptr_ff + ONE;
            end
            idx_in   = idx_inc;
            state_in = S_SCAN_RD;
         end

         // insertion: shift larger entries up one slot until the spot is found
         S_INS_RD: begin
            if (idx_ff == '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = key_ff;
               count_in    = count_ff + ONE;
               state_in    = S_FIN;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = pos_dec[IW-1:0];
               state_in    = S_INS_USE;
            end
         end

         S_INS_USE: begin
            cmp_op    = CMP_AFTER;
            ram_wr_en = 1'b1;
            if (cmp_res.hit) begin
               ram_wr_data = ram_rd_data;
               idx_in      = pos_dec;
               state_in    = S_INS_RD;
            end else begin
               ram_wr_data = key_ff;
               count_in    = count_ff + ONE;
               state_in    = S_FIN;
            end
         end

         S_LIST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_LIST_USE;
         end

         // list walk, holds on the current entry while the response is stalled
         S_LIST_USE: begin
            cmp_op = CMP_MERGE;
            if (mode_ff == MODE_LIST) begin
               if (out_free) begin
                  rsp_load           = 1'b1;
                  rsp_next.status    = ST_OK;
                  rsp_next.is_free   = 1'b0;
                  rsp_next.out_start = ram_rd_data.rng_start;
                  rsp_next.out_end   = ram_rd_data.rng_end;
                  rsp_next.last      = idx_last;
                  idx_in             = idx_inc;
                  state_in           = idx_last ? S_IDLE : S_LIST_RD;
               end
            end else if (!need_emit || out_free) begin
               if (need_emit) begin
                  rsp_load           = 1'b1;
                  rsp_next.status    = ST_OK;
                  rsp_next.is_free   = 1'b0;
                  rsp_next.out_start = acc_ff.rng_start;
                  rsp_next.out_end   = acc_ff.rng_end;
                  rsp_next.last      = 1'b0;
               end
               if ((idx_ff == '0) || need_emit) begin
                  acc_in = ram_rd_data;
               end else if (cmp_res.grow) begin
                  acc_in.rng_end = ram_rd_data.rng_end;
               end
               idx_in   = idx_inc;
               // the open merged run goes out as the final response
               state_in = idx_last ? S_FIN : S_LIST_RD;
            end
         end

         // single or closing response
         S_FIN: begin
            if (out_free) begin
               rsp_load           = 1'b1;
               rsp_next.status    = res_status_ff;
               rsp_next.is_free   = res_free_ff;
               rsp_next.out_start = acc_ff.rng_start;
               rsp_next.out_end   = acc_ff.rng_end;
               rsp_next.last      = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_load ? rsp_next : rsp_data_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      wr_ptr_ff     <= wr_ptr_in;
      acc_ff        <= acc_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_free_ff   <= res_free_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // table never holds more ranges than it has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above table size");

   // the walk never reads and writes the table in the same cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("table read and write in one cycle");

   // compaction never writes ahead of the entry being read
   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN_USE) |-> (wr_ptr_ff <= idx_ff))
      else $error("compaction pointer passed read index");

   // the response marked last ends the request
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_next.last) |=> (state_ff == S_IDLE))
      else $error("last response without return to idle");

endmodule
